[hdl/sacl_pkg.sv]
// Shared constants, types and codes for the set-associative LRU cache tag model.
package sacl_pkg;

  // Default geometry limits
  localparam int unsigned MAX_SET_BITS_DEF = 6;
  localparam int unsigned MAX_WAYS_DEF     = 8;

  // Field widths
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OUT_W   = 104;  // 3 flags + 3 counters, padded to bytes
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 6;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_WAYS       = 2'd2;

  // Configuration register values
  typedef struct packed {
    logic [2:0] set_bits;
    logic [5:0] block_bits;
    logic [3:0] ways;
  } cfg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_UPD_A,
    ST_READ_B,
    ST_UPD_B
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture input transfer
    logic read;    // read the set row
    logic update;  // resolve access, write row back, load result
    logic last;    // this access ends the item
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mode;       // captured item is a modify
    logic out_stall;  // result register full and not taken this cycle
  } sts_t;

endpackage

[hdl/sacl_cfg.sv]
// Configuration register file: set bits, block bits and ways in use.
module sacl_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sacl_pkg::CIDX_W-1:0]     cfg_index_i,
  input  logic [sacl_pkg::CDATA_W-1:0]    cfg_data_i,
  output sacl_pkg::cfg_t                  cfg_o
);

  sacl_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  // Register write decode; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sacl_pkg::CFG_SET_BITS:   cfg_d.set_bits   = cfg_data_i[2:0];
        sacl_pkg::CFG_BLOCK_BITS: cfg_d.block_bits = cfg_data_i[5:0];
        sacl_pkg::CFG_WAYS:       cfg_d.ways       = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_bits   <= 3'd0;
      cfg_q.block_bits <= 6'd1;
      cfg_q.ways       <= 4'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/sacl_ctrl.sv]
// Controller state machine: sequences read and update of one or two accesses.
module sacl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sacl_pkg::sts_t   sts_i,
  output sacl_pkg::cmd_t   cmd_o
);

  sacl_pkg::state_e state_d, state_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sacl_pkg::ST_IDLE:   if (in_valid_i) state_d = sacl_pkg::ST_READ_A;
      sacl_pkg::ST_READ_A: state_d = sacl_pkg::ST_UPD_A;
      sacl_pkg::ST_UPD_A: begin
        if (!sts_i.out_stall) begin
          state_d = sts_i.mode ? sacl_pkg::ST_READ_B : sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_READ_B: state_d = sacl_pkg::ST_UPD_B;
      sacl_pkg::ST_UPD_B:  if (!sts_i.out_stall) state_d = sacl_pkg::ST_IDLE;
      default:             state_d = sacl_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sacl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sacl_pkg::ST_READ_A, sacl_pkg::ST_READ_B: cmd_o.read = 1'b1;
      sacl_pkg::ST_UPD_A: begin
        cmd_o.update = !sts_i.out_stall;
        cmd_o.last   = !sts_i.mode;
      end
      sacl_pkg::ST_UPD_B: begin
        cmd_o.update = !sts_i.out_stall;
        cmd_o.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sacl_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

[hdl/sacl_dpath.sv]
// Datapath: index/tag split, set row memory, hit/fill/victim logic, counters, result register.
module sacl_dpath #(
  parameter int unsigned MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sacl_pkg::cfg_t                cfg_i,
  input  sacl_pkg::cmd_t                cmd_i,
  output sacl_pkg::sts_t                sts_o,
  input  logic [sacl_pkg::ADDR_W-1:0]   addr_i,
  input  logic                          mode_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [sacl_pkg::OUT_W-1:0]    out_data_o,
  output logic                          out_last_o
);

  localparam int unsigned SETS  = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned AGE_W = WAY_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
  localparam int unsigned AW = sacl_pkg::ADDR_W;
  localparam int unsigned CW = sacl_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_MAX = '1;

  // Captured item
  logic [AW-1:0] addr_q;
  logic          mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cmd_i.load) begin
      mode_q <= mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) addr_q <= addr_i;
  end

  // Effective geometry
  logic [3:0]       sb;
  logic [4:0]       nways;
  logic [6:0]       tag_sh;
  logic [AW-1:0]    blk_shifted;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_idx;
  logic [AW-1:0]    tag_c;

  always_comb begin
    if ({1'b0, cfg_i.set_bits} > 4'(MAX_SET_BITS)) sb = 4'(MAX_SET_BITS);
    else                                          sb = {1'b0, cfg_i.set_bits};
    if (cfg_i.ways == 4'd0)                       nways = 5'd1;
    else if ({1'b0, cfg_i.ways} > 5'(MAX_WAYS))   nways = 5'(MAX_WAYS);
    else                                          nways = {1'b0, cfg_i.ways};
    for (int j = 0; j < SET_W; j++) begin
      set_mask[j] = (4'(j) < sb);
    end
    blk_shifted = addr_q >> cfg_i.block_bits;
    set_idx     = blk_shifted[SET_W-1:0] & set_mask;
    tag_sh      = {3'd0, sb} + {1'b0, cfg_i.block_bits};
    tag_c       = (tag_sh >= 7'd64) ? '0 : (addr_q >> tag_sh[5:0]);
  end

  // Set row memory and row-written flags
  logic [MAX_WAYS-1:0]            mem_vld [SETS];
  logic [MAX_WAYS-1:0][AW-1:0]    mem_tag [SETS];
  logic [MAX_WAYS-1:0][AGE_W-1:0] mem_age [SETS];
  logic [SETS-1:0]                row_init_q;

  logic                           rd_init_q;
  logic [MAX_WAYS-1:0]            rd_vld_q;
  logic [MAX_WAYS-1:0][AW-1:0]    rd_tag_q;
  logic [MAX_WAYS-1:0][AGE_W-1:0] rd_age_q;

  logic [MAX_WAYS-1:0]            wr_vld;
  logic [MAX_WAYS-1:0][AW-1:0]    wr_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0] wr_age;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem_vld[set_idx] <= wr_vld;
      mem_tag[set_idx] <= wr_tag;
      mem_age[set_idx] <= wr_age;
    end
    if (cmd_i.read) begin
      rd_vld_q <= mem_vld[set_idx];
      rd_tag_q <= mem_tag[set_idx];
      rd_age_q <= mem_age[set_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
      rd_init_q  <= 1'b0;
    end else begin
      if (cmd_i.update) row_init_q[set_idx] <= 1'b1;
      if (cmd_i.read)   rd_init_q <= row_init_q[set_idx];
    end
  end

  // Lookup: hit way, first free way, LRU victim
  logic [MAX_WAYS-1:0]            eff_vld;
  logic [MAX_WAYS-1:0][AGE_W-1:0] eff_age;
  logic [MAX_WAYS-1:0]            in_use;
  logic                           hit, has_free, fill, evict;
  logic [WAY_W-1:0]               hit_way, free_way, victim, sel_way;
  logic [AGE_W-1:0]               best, old_age;

  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    victim   = '0;
    best     = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      eff_vld[j] = rd_vld_q[j] & rd_init_q;
      eff_age[j] = rd_init_q ? rd_age_q[j] : '0;
      in_use[j]  = (5'(j) < nways);
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (in_use[j]) begin
        if (eff_vld[j]) begin
          if (!hit && rd_tag_q[j] == tag_c) begin
            hit     = 1'b1;
            hit_way = WAY_W'(j);
          end
        end else if (!has_free) begin
          has_free = 1'b1;
          free_way = WAY_W'(j);
        end
        if (j == 0 || eff_age[j] > best) begin
          best   = eff_age[j];
          victim = WAY_W'(j);
        end
      end
    end
    fill  = !hit && has_free;
    evict = !hit && !has_free;
    if (hit)       sel_way = hit_way;
    else if (fill) sel_way = free_way;
    else           sel_way = victim;
    old_age = hit ? eff_age[hit_way] : best;
  end

  // Row write-back with recency update
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      wr_vld[j] = eff_vld[j];
      wr_tag[j] = rd_tag_q[j];
      wr_age[j] = eff_age[j];
      if (WAY_W'(j) == sel_way) begin
        wr_vld[j] = 1'b1;
        wr_age[j] = '0;
        if (!hit) wr_tag[j] = tag_c;
      end else if (in_use[j] && eff_vld[j] && (fill || eff_age[j] < old_age)
                   && eff_age[j] < AGE_MAX) begin
        wr_age[j] = eff_age[j] + AGE_W'(1);
      end
    end
  end

  // Saturating totals
  logic [CW-1:0] hits_q, misses_q, evicts_q;
  logic [CW-1:0] hits_d, misses_d, evicts_d;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (hit && hits_q != CNT_MAX)       hits_d   = hits_q + CW'(1);
    if (!hit && misses_q != CNT_MAX)    misses_d = misses_q + CW'(1);
    if (evict && evicts_q != CNT_MAX)   evicts_d = evicts_q + CW'(1);
  end

  // Result register
  logic out_valid_q;
  logic [sacl_pkg::OUT_W-1:0] out_data_q;
  logic out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        evicts_q    <= evicts_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_data_q <= {5'd0, evicts_d, misses_d, hits_d, evict, !hit, hit};
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign sts_o       = '{mode: mode_q, out_stall: out_valid_q && !out_ready_i};

endmodule

[hdl/set_assoc_cache_lru_model.sv]
// Each access makes a registered read of the set row memory, then resolves the access,
// writes the row back and loads the result register; a modify makes two accesses. A new
// item is taken only in idle, after its last update; a result not taken stalls updates.
// Reset: asynchronous, active low; all lines read invalid at once through per-set flags,
// the totals clear and the configuration returns to set_bits 0, block_bits 1, ways 1.
module set_assoc_cache_lru_model #(
  parameter int unsigned MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sacl_pkg::ADDR_W-1:0]   s_axis_tdata,   // address
  input  logic                          s_axis_tuser,   // mode
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // was_hit, was_miss, did_evict, total_hits, total_misses, total_evictions, zero pad
  output logic [sacl_pkg::OUT_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast,   // last_of_item
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sacl_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [sacl_pkg::CDATA_W-1:0]  cfg_data_i
);

  sacl_pkg::cfg_t cfg;
  sacl_pkg::cmd_t cmd;
  sacl_pkg::sts_t sts;

  sacl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sacl_dpath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .addr_i      (s_axis_tdata),
    .mode_i      (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
